/* rtl/srcp_pkg.sv */
// Shared types, constants and arithmetic helpers for the serial RTC calendar port.
`default_nettype none
package srcp_pkg;

    localparam int unsigned NUM_DIGITS = 13;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic [1:0] MODE_READY   = 2'd0;
    localparam logic [1:0] MODE_COMMAND = 2'd1;
    localparam logic [1:0] MODE_READ    = 2'd2;
    localparam logic [1:0] MODE_WRITE   = 2'd3;

    localparam logic [3:0] NIB_START = 4'h0;
    localparam logic [3:0] NIB_CLEAR = 4'h4;
    localparam logic [3:0] NIB_READ  = 4'hD;
    localparam logic [3:0] NIB_CMD   = 4'hE;
    localparam logic [3:0] NIB_NOP   = 4'hF;
    localparam logic [3:0] MARKER    = 4'hF;

    localparam logic [4:0] PTR_NONE  = 5'h1F;
    localparam logic [4:0] PTR_LAST  = 5'd11;
    localparam logic [4:0] PTR_WDAY  = 5'd12;
    localparam logic [4:0] PTR_DONE  = 5'd13;

    localparam logic [11:0] YEAR_OFFSET = 12'd1000;
    localparam logic [11:0] YEAR_EPOCH  = 12'd1900;
    localparam logic [1:0]  EPOCH_CENT4 = 2'd3;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK_STEP,
        ST_TICK_WB,
        ST_WD_INIT,
        ST_WD_YEAR,
        ST_WD_MONTH,
        ST_WD_DONE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic exec;
        logic tick_step;
        logic tick_wb;
        logic wd_init;
        logic wd_year;
        logic wd_month;
        logic wd_done;
        logic emit;
    } t_ctl;

    typedef struct packed {
        logic is_tick;
        logic wd_needed;
        logic sec_over;
        logic year_more;
        logic month_more;
        logic out_free;
    } t_stat;

    function automatic logic [10:0] div10(input logic [10:0] x);
        logic [29:0] p;
        p = 30'(x) * 30'd52429;
        return p[29:19];
    endfunction

    function automatic logic [4:0] div100(input logic [10:0] x);
        logic [23:0] p;
        p = 24'(x) * 24'd5243;
        return p[23:19];
    endfunction

    function automatic logic [2:0] mod7(input logic [5:0] x);
        logic [5:0] v;
        v = x;
        if (v >= 6'd28) v = v - 6'd28;
        if (v >= 6'd14) v = v - 6'd14;
        if (v >= 6'd7)  v = v - 6'd7;
        return v[2:0];
    endfunction

    function automatic logic [7:0] pair(input logic [3:0] u, input logic [3:0] t);
        return 8'(u) + 8'(t) * 8'd10;
    endfunction

endpackage
`default_nettype wire

/* rtl/srcp_ctrl.sv */
// Sequencing state machine for the serial RTC calendar port.
`default_nettype none
module srcp_ctrl
    import srcp_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    input  wire t_stat  i_stat,
    output t_ctl        o_ctl,
    output logic        o_stall,
    output t_state      o_state
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_stat.is_tick)        n_state = ST_TICK_STEP;
                    else if (i_stat.wd_needed) n_state = ST_WD_INIT;
                    else                       n_state = ST_EMIT;
                end
            end
            ST_TICK_STEP: if (!i_stat.sec_over) n_state = ST_TICK_WB;
            ST_TICK_WB:   n_state = ST_EMIT;
            ST_WD_INIT:   n_state = ST_WD_YEAR;
            ST_WD_YEAR:   if (!i_stat.year_more) n_state = ST_WD_MONTH;
            ST_WD_MONTH:  if (!i_stat.month_more) n_state = ST_WD_DONE;
            ST_WD_DONE:   n_state = ST_EMIT;
            ST_EMIT:      if (i_stat.out_free) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctl   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_stall    = 1'b0;
                o_ctl.exec = i_valid;
            end
            ST_TICK_STEP: o_ctl.tick_step = i_stat.sec_over;
            ST_TICK_WB:   o_ctl.tick_wb   = 1'b1;
            ST_WD_INIT:   o_ctl.wd_init   = 1'b1;
            ST_WD_YEAR:   o_ctl.wd_year   = i_stat.year_more;
            ST_WD_MONTH:  o_ctl.wd_month  = i_stat.month_more;
            ST_WD_DONE:   o_ctl.wd_done   = 1'b1;
            ST_EMIT:      o_ctl.emit      = i_stat.out_free;
            default:      o_ctl           = '0;
        endcase
    end

    assign o_state = r_state;

endmodule
`default_nettype wire

/* rtl/srcp_dp.sv */
// Digit store, port decoding, second carry and weekday walk datapath.
`default_nettype none
module srcp_dp
    import srcp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_ctl       i_ctl,
    input  wire logic [1:0] i_cmd,
    input  wire logic [3:0] i_write_data,
    input  wire logic       i_stall,
    output t_stat           o_stat,
    output logic            o_valid,
    output logic [3:0]      o_read_data
);

    logic [3:0]  r_store [NUM_DIGITS];
    logic [3:0]  n_store [NUM_DIGITS];
    logic [1:0]  r_mode, n_mode;
    logic [4:0]  r_ptr, n_ptr;
    logic [3:0]  r_res, n_res;

    logic [7:0]  r_sec, r_min, r_hr, r_day;
    logic [7:0]  n_sec, n_min, n_hr, n_day;
    logic [3:0]  r_mon, n_mon, r_wd, n_wd;
    logic [10:0] r_yr, n_yr;
    logic        r_leap, n_leap;

    logic [11:0] r_yt, n_yt, r_y, n_y;
    logic [1:0]  r_y4, n_y4, r_c4, n_c4;
    logic [6:0]  r_y100, n_y100;
    logic [2:0]  r_acc, n_acc;
    logic [3:0]  r_m, n_m, r_mt, n_mt;
    logic [4:0]  r_dt, n_dt;

    logic        r_out_valid;
    logic [3:0]  r_out_data;

    logic [3:0]  v;
    logic [7:0]  t_yr, t_day;
    logic [4:0]  cent;
    logic [10:0] y_full;
    logic [11:0] y_abs;
    logic [3:0]  m_idx;
    logic [4:0]  m_len;
    logic        leap_w;
    logic [10:0] q_sec, q_min, q_hr, q_day, q_y10;
    logic [4:0]  q_y100;
    logic [10:0] r10;

    assign v = i_write_data;

    always_comb begin
        t_yr   = pair(r_store[9], r_store[10]);
        cent   = 5'(r_store[11]) + 5'd10 + 5'((t_yr >= 8'd100) ? 1 : 0);
        y_full = 11'(t_yr) + 11'(r_store[11]) * 11'd100;
        y_abs  = 12'(y_full) + YEAR_OFFSET;
        t_day  = pair(r_store[6], r_store[7]);
        leap_w = (r_y4 == 2'd0) && !((r_y100 == 7'd0) && (r_c4 != 2'd0));
        if (r_mon == 4'd0)       m_idx = 4'd3;
        else if (r_mon >= 4'd13) m_idx = r_mon - 4'd13;
        else                     m_idx = r_mon - 4'd1;
        m_len = MONTH_LEN[m_idx];
        if ((m_idx == 4'd1) && r_leap) m_len = m_len + 5'd1;
        q_sec  = div10(11'(r_sec));
        q_min  = div10(11'(r_min));
        q_hr   = div10(11'(r_hr));
        q_day  = div10(11'(r_day));
        q_y10  = div10(r_yr);
        q_y100 = div100(r_yr);
        r10    = r_yr - q_y10 * 11'd10;
    end

    always_comb begin
        n_store = r_store;
        n_mode  = r_mode;
        n_ptr   = r_ptr;
        n_res   = r_res;
        n_sec = r_sec; n_min = r_min; n_hr = r_hr; n_day = r_day;
        n_mon = r_mon; n_wd = r_wd; n_yr = r_yr; n_leap = r_leap;
        n_yt = r_yt; n_y = r_y; n_y4 = r_y4; n_c4 = r_c4; n_y100 = r_y100;
        n_acc = r_acc; n_m = r_m; n_mt = r_mt; n_dt = r_dt;

        if (i_ctl.exec) begin
            n_res = 4'd0;
            case (i_cmd)
                CMD_READ: begin
                    if (r_mode == MODE_READ) begin
                        if (r_ptr[4]) begin
                            n_res = MARKER;
                            n_ptr = 5'd0;
                        end else if (r_ptr > PTR_WDAY) begin
                            n_res = MARKER;
                            n_ptr = PTR_NONE;
                        end else begin
                            n_res = r_store[r_ptr[3:0]];
                            n_ptr = r_ptr + 5'd1;
                        end
                    end
                end
                CMD_WRITE: begin
                    if (v == NIB_READ) begin
                        n_mode = MODE_READ;
                        n_ptr  = PTR_NONE;
                    end else if (v == NIB_CMD) begin
                        n_mode = MODE_COMMAND;
                    end else if (v == NIB_NOP) begin
                        n_mode = r_mode;
                    end else if (r_mode == MODE_WRITE) begin
                        if (!r_ptr[4] && (r_ptr <= PTR_LAST)) begin
                            n_store[r_ptr[3:0]] = v;
                            n_ptr = (r_ptr == PTR_LAST) ? PTR_DONE : r_ptr + 5'd1;
                        end
                    end else if (r_mode == MODE_COMMAND) begin
                        if (v == NIB_START) begin
                            n_mode = MODE_WRITE;
                            n_ptr  = 5'd0;
                        end else if (v == NIB_CLEAR) begin
                            n_mode = MODE_READY;
                            n_ptr  = PTR_NONE;
                            for (int i = 0; i < NUM_DIGITS; i++) n_store[i] = 4'd0;
                        end else begin
                            n_mode = MODE_READY;
                        end
                    end
                end
                CMD_TICK: begin
                    n_sec  = pair(r_store[0], r_store[1]) + 8'd1;
                    n_min  = pair(r_store[2], r_store[3]);
                    n_hr   = pair(r_store[4], r_store[5]);
                    n_day  = t_day;
                    n_mon  = r_store[8];
                    n_yr   = y_full;
                    n_wd   = r_store[12];
                    n_leap = (t_yr[1:0] == 2'd0)
                          && !(((t_yr == 8'd0) || (t_yr == 8'd100)) && (cent[1:0] != 2'd0));
                end
                default: n_res = 4'd0;
            endcase
        end

        if (i_ctl.tick_step) begin
            n_sec = r_sec - 8'd60;
            n_min = r_min + 8'd1;
            if (n_min >= 8'd60) begin
                n_min = 8'd0;
                n_hr  = r_hr + 8'd1;
                if (n_hr >= 8'd24) begin
                    n_hr = 8'd0;
                    n_wd = 4'(mod7(6'(r_wd) + 6'd1));
                    if (r_day < 8'(m_len)) begin
                        n_day = r_day + 8'd1;
                    end else begin
                        n_day = 8'd1;
                        if (r_mon < 4'd12) begin
                            n_mon = r_mon + 4'd1;
                        end else begin
                            n_mon = 4'd1;
                            n_yr  = r_yr + 11'd1;
                        end
                    end
                end
            end
        end

        if (i_ctl.tick_wb) begin
            n_store[0]  = 4'(r_sec - 8'(q_sec * 11'd10));
            n_store[1]  = q_sec[3:0];
            n_store[2]  = 4'(r_min - 8'(q_min * 11'd10));
            n_store[3]  = q_min[3:0];
            n_store[4]  = 4'(r_hr - 8'(q_hr * 11'd10));
            n_store[5]  = q_hr[3:0];
            n_store[6]  = 4'(r_day - 8'(q_day * 11'd10));
            n_store[7]  = q_day[3:0];
            n_store[8]  = r_mon;
            n_store[9]  = r10[3:0];
            n_store[10] = 4'(q_y10 - 11'(q_y100) * 11'd10);
            n_store[11] = 4'(q_y100);
            n_store[12] = 4'(mod7(6'(r_wd)));
        end

        if (i_ctl.wd_init) begin
            n_yt   = (y_abs < YEAR_EPOCH) ? YEAR_EPOCH : y_abs;
            n_y    = YEAR_EPOCH;
            n_y4   = 2'd0;
            n_y100 = 7'd0;
            n_c4   = EPOCH_CENT4;
            n_acc  = 3'd0;
            n_m    = 4'd1;
            if (r_store[8] == 4'd0)      n_mt = 4'd1;
            else if (r_store[8] > 4'd12) n_mt = 4'd12;
            else                         n_mt = r_store[8];
            if (t_day == 8'd0)      n_dt = 5'd1;
            else if (t_day > 8'd31) n_dt = 5'd31;
            else                    n_dt = t_day[4:0];
        end

        if (i_ctl.wd_year) begin
            n_acc = mod7(6'(r_acc) + (leap_w ? 6'd2 : 6'd1));
            n_y   = r_y + 12'd1;
            n_y4  = r_y4 + 2'd1;
            if (r_y100 == 7'd99) begin
                n_y100 = 7'd0;
                n_c4   = r_c4 + 2'd1;
            end else begin
                n_y100 = r_y100 + 7'd1;
            end
        end

        if (i_ctl.wd_month) begin
            n_acc = mod7(6'(r_acc) + 6'(MONTH_LEN[r_m - 4'd1])
                         + (((r_m == 4'd2) && leap_w) ? 6'd1 : 6'd0));
            n_m   = r_m + 4'd1;
        end

        if (i_ctl.wd_done) begin
            n_store[12] = 4'(mod7(6'(r_acc) + 6'(r_dt)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_DIGITS; i++) r_store[i] <= 4'd0;
            r_mode      <= MODE_READ;
            r_ptr       <= PTR_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_store <= n_store;
            r_mode  <= n_mode;
            r_ptr   <= n_ptr;
            if (i_ctl.emit)    r_out_valid <= 1'b1;
            else if (!i_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_sec <= n_sec; r_min <= n_min; r_hr <= n_hr; r_day <= n_day;
        r_mon <= n_mon; r_wd <= n_wd; r_yr <= n_yr; r_leap <= n_leap;
        r_yt <= n_yt; r_y <= n_y; r_y4 <= n_y4; r_c4 <= n_c4; r_y100 <= n_y100;
        r_acc <= n_acc; r_m <= n_m; r_mt <= n_mt; r_dt <= n_dt;
        if (i_ctl.emit) r_out_data <= r_res;
    end

    always_comb begin
        o_stat.is_tick    = (i_cmd == CMD_TICK);
        o_stat.wd_needed  = (i_cmd == CMD_WRITE) && (v != NIB_READ) && (v != NIB_CMD)
                         && (v != NIB_NOP) && (r_mode == MODE_WRITE) && (r_ptr == PTR_LAST);
        o_stat.sec_over   = (r_sec >= 8'd60);
        o_stat.year_more  = (r_y < r_yt);
        o_stat.month_more = (r_m < r_mt);
        o_stat.out_free   = !r_out_valid || !i_stall;
    end

    assign o_valid     = r_out_valid;
    assign o_read_data = r_out_data;

endmodule
`default_nettype wire

/* rtl/serial_rtc_calendar_port_unit.sv */
// Top level of the serial RTC calendar port: controller, datapath and checks.
//
// Input channel: i_valid / o_stall carry i_cmd (read, command write, tick)
// and i_write_data. A transfer happens when i_valid is high and o_stall low.
// Output channel: o_valid / i_stall carry o_read_data, one result per input.
// Reads, command writes and no-ops other than the twelfth digit: idle, then
// emit, which loads the output register once free; input taken only in idle.
// Tick: idle, then the iterative seconds carry (one carry pass per cycle, at
// most two passes), the digit write-back state and emit.
// Writing the twelfth digit starts the weekday walk: one year per cycle from
// 1900 up to the written year, one month per cycle, then the store.
// Reset (synchronous, i_rst_n low) clears all digits, selects read mode and
// parks the digit pointer before the leading frame marker.
// While i_stall holds a result, it stays on o_read_data; the block finishes
// the following item and then waits with o_stall high until the output
// register frees.
`default_nettype none
module serial_rtc_calendar_port_unit
    import srcp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [1:0] i_cmd,
    input  wire logic [3:0] i_write_data,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [3:0]      o_read_data
);

    t_ctl   w_ctl;
    t_stat  w_stat;
    t_state w_state;

    srcp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (w_stat),
        .o_ctl   (w_ctl),
        .o_stall (o_stall),
        .o_state (w_state)
    );

    srcp_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_cmd        (i_cmd),
        .i_write_data (i_write_data),
        .i_stall      (i_stall),
        .o_stat       (w_stat),
        .o_valid      (o_valid),
        .o_read_data  (o_read_data)
    );

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken while previous item still in progress");

    a_short_item_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !w_stat.is_tick && !w_stat.wd_needed)
        |=> (w_state == ST_EMIT))
        else $error("plain port access did not go straight to emit");

    a_emit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_state == ST_EMIT && w_stat.out_free) |=> o_valid)
        else $error("result not presented after emit");

endmodule
`default_nettype wire

/* tb/sv/tb_serial_rtc_calendar_port_unit.sv */
// Testbench for the serial RTC calendar port: directed and random transfers against a predictor.
module tb_serial_rtc_calendar_port_unit;
    import srcp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_IDLE = 2'd3;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [1:0] i_cmd;
    logic [3:0] i_write_data;
    logic       o_valid;
    logic       i_stall;
    logic [3:0] o_read_data;

    serial_rtc_calendar_port_unit uut (.*);

    logic [3:0] clk_digits [13];
    logic [1:0] clk_mode;
    int         clk_ptr;
    logic [3:0] read_expect_q [$];
    int         errors;
    bit         stall_quiet;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #100ms;
        $display("FAIL");
        $finish;
    end

    function automatic bit leap_year(int unsigned y);
        if (y % 4 != 0) return 1'b0;
        if (y % 100 == 0 && y % 400 != 0) return 1'b0;
        return 1'b1;
    endfunction

    function automatic int unsigned month_days(int unsigned m0, int unsigned y);
        int unsigned n;
        n = MONTH_LEN[m0 % 12];
        if (n == 28 && leap_year(y)) n++;
        return n;
    endfunction

    function automatic logic [3:0] weekday_of(int unsigned yr, int unsigned mo,
                                               int unsigned dy);
        int unsigned y;
        int unsigned m;
        int unsigned s;
        y = 1900;
        m = 1;
        s = 0;
        if (yr < 1900) yr = 1900;
        if (mo < 1) mo = 1;
        if (mo > 12) mo = 12;
        if (dy < 1) dy = 1;
        if (dy > 31) dy = 31;
        while (y < yr) begin
            s += leap_year(y) ? 366 : 365;
            y++;
        end
        while (m < mo) begin
            s += month_days(m - 1, y);
            m++;
        end
        s += dy - 1;
        return 4'((s + 1) % 7);
    endfunction

    task automatic clock_tick();
        int unsigned sec, mn, hr, dy, mo, yr, wd;
        sec = clk_digits[0] + clk_digits[1] * 10;
        mn  = clk_digits[2] + clk_digits[3] * 10;
        hr  = clk_digits[4] + clk_digits[5] * 10;
        dy  = clk_digits[6] + clk_digits[7] * 10 - 1;
        mo  = clk_digits[8] - 1;
        yr  = clk_digits[9] + clk_digits[10] * 10 + clk_digits[11] * 100 + 1000;
        wd  = clk_digits[12];
        sec++;
        while (sec >= 60) begin
            sec -= 60;
            mn++;
            if (mn >= 60) begin
                mn = 0;
                hr++;
                if (hr >= 24) begin
                    hr = 0;
                    dy++;
                    wd = (wd + 1) % 7;
                    if (dy >= month_days(mo, yr)) begin
                        dy = 0;
                        mo++;
                        if (mo >= 12) begin
                            mo = 0;
                            yr++;
                        end
                    end
                end
            end
        end
        dy++;
        mo++;
        yr -= 1000;
        clk_digits[0]  = 4'(sec % 10);
        clk_digits[1]  = 4'(sec / 10);
        clk_digits[2]  = 4'(mn % 10);
        clk_digits[3]  = 4'(mn / 10);
        clk_digits[4]  = 4'(hr % 10);
        clk_digits[5]  = 4'(hr / 10);
        clk_digits[6]  = 4'(dy % 10);
        clk_digits[7]  = 4'(dy / 10);
        clk_digits[8]  = 4'(mo);
        clk_digits[9]  = 4'(yr % 10);
        clk_digits[10] = 4'((yr / 10) % 10);
        clk_digits[11] = 4'(yr / 100);
        clk_digits[12] = 4'(wd % 7);
    endtask

    task automatic port_nibble(logic [3:0] v);
        if (v == NIB_READ) begin
            clk_mode = MODE_READ;
            clk_ptr  = -1;
        end else if (v == NIB_CMD) begin
            clk_mode = MODE_COMMAND;
        end else if (v == NIB_NOP) begin
        end else if (clk_mode == MODE_WRITE) begin
            if (clk_ptr >= 0 && clk_ptr < 12) begin
                clk_digits[clk_ptr] = v;
                clk_ptr++;
                if (clk_ptr == 12) begin
                    clk_digits[12] = weekday_of(
                        clk_digits[9] + clk_digits[10] * 10 + clk_digits[11] * 100 + 1000,
                        clk_digits[8], clk_digits[6] + clk_digits[7] * 10);
                    clk_ptr = 13;
                end
            end
        end else if (clk_mode == MODE_COMMAND) begin
            if (v == NIB_START) begin
                clk_mode = MODE_WRITE;
                clk_ptr  = 0;
            end else if (v == NIB_CLEAR) begin
                clk_mode = MODE_READY;
                clk_ptr  = -1;
                foreach (clk_digits[i]) clk_digits[i] = '0;
            end else begin
                clk_mode = MODE_READY;
            end
        end
    endtask

    function automatic logic [3:0] port_read();
        if (clk_mode != MODE_READ) return '0;
        if (clk_ptr < 0) begin
            clk_ptr = 0;
            return MARKER;
        end
        if (clk_ptr > 12) begin
            clk_ptr = -1;
            return MARKER;
        end
        clk_ptr++;
        return clk_digits[clk_ptr - 1];
    endfunction

    task automatic predict_transfer(logic [1:0] c, logic [3:0] d);
        logic [3:0] r;
        r = '0;
        if (c == CMD_READ) r = port_read();
        else if (c == CMD_WRITE) port_nibble(d);
        else if (c == CMD_TICK) clock_tick();
        read_expect_q.push_back(r);
    endtask

    function automatic int gap_len();
        if ($urandom_range(0, 2) == 0) return 0;
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
    endfunction

    task automatic send(logic [1:0] c, logic [3:0] d);
        int g;
        g = stall_quiet ? 0 : gap_len();
        repeat (g) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_cmd        <= c;
        i_write_data <= d;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_transfer(c, d);
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (read_expect_q.size() == 0) begin
                $display("%t unexpected result: expected none, actual %h", $time, o_read_data);
                errors++;
            end else begin
                if (o_read_data !== read_expect_q[0]) begin
                    $display("%t read_data mismatch: expected %h, actual %h",
                             $time, read_expect_q[0], o_read_data);
                    errors++;
                end
                void'(read_expect_q.pop_front());
            end
        end
    end

    int stall_left;
    always @(posedge i_clk) begin
        if (stall_quiet) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else if ($urandom_range(0, 3) == 0) begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                       : $urandom_range(0, 2);
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic write_date(logic [3:0] dg [12]);
        send(CMD_WRITE, NIB_CMD);
        send(CMD_WRITE, NIB_START);
        foreach (dg[i]) send(CMD_WRITE, dg[i]);
    endtask

    task automatic read_all();
        send(CMD_WRITE, NIB_READ);
        repeat (15) send(CMD_READ, '0);
    endtask

    task automatic test_reset_read();
        repeat (16) send(CMD_READ, '0);
    endtask

    task automatic test_rollover();
        logic [3:0] dg [12];
        dg = '{4'd9, 4'd5, 4'd9, 4'd5, 4'd3, 4'd2, 4'd8, 4'd2, 4'd2, 4'd0, 4'd0, 4'd10};
        write_date(dg);
        send(CMD_TICK, '0);
        read_all();
    endtask

    task automatic test_modes();
        send(CMD_WRITE, NIB_NOP);
        send(CMD_IDLE, 4'hA);
        send(CMD_READ, '0);
        send(CMD_WRITE, NIB_CMD);
        send(CMD_WRITE, 4'h7);
        send(CMD_READ, '0);
        send(CMD_WRITE, NIB_CMD);
        send(CMD_WRITE, NIB_CLEAR);
        send(CMD_TICK, 4'hF);
        read_all();
    endtask

    task automatic test_extremes();
        logic [3:0] dg [12];
        foreach (dg[i]) dg[i] = 4'hC;
        write_date(dg);
        send(CMD_WRITE, 4'h5);
        repeat (3) send(CMD_TICK, '0);
        read_all();
    endtask

    task automatic test_random(int n);
        logic [3:0] dg [12];
        int k;
        int nt;
        k = 0;
        while (k < n) begin
            stall_quiet = ($urandom_range(0, 7) == 0);
            case ($urandom_range(0, 5))
                0, 1: begin
                    foreach (dg[i]) dg[i] = ($urandom_range(0, 9) == 0) ?
                        4'($urandom_range(0, 12)) : 4'($urandom_range(0, 9));
                    dg[11] = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 12))
                                                          : 4'($urandom_range(9, 10));
                    dg[8]  = 4'($urandom_range(0, 12));
                    dg[1]  = 4'($urandom_range(0, 5));
                    dg[0]  = 4'($urandom_range(8, 9));
                    write_date(dg);
                    k += 14;
                end
                2: begin
                    nt = $urandom_range(1, 70);
                    repeat (nt) send(CMD_TICK, 4'($urandom));
                    k += nt;
                end
                3: begin
                    read_all();
                    k += 16;
                end
                default: begin
                    send(2'($urandom), 4'($urandom));
                    k++;
                end
            endcase
        end
        stall_quiet = 1'b0;
    endtask

    initial begin
        errors       = 0;
        stall_quiet  = 1'b0;
        stall_left   = 0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_stall      = 1'b0;
        i_cmd        = CMD_READ;
        i_write_data = '0;
        foreach (clk_digits[i]) clk_digits[i] = '0;
        clk_mode = MODE_READ;
        clk_ptr  = -1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_read();
        test_rollover();
        test_modes();
        test_extremes();
        test_random(950);
        while (read_expect_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0 && read_expect_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
